// ----- rtl/assert_macros.svh -----
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- rtl/tma_pkg.sv -----
// ----------------------------------------------------------------------------
// tma_pkg
// shared types and constants of the transverse mass accumulator
// ----------------------------------------------------------------------------
`default_nettype none
package tma_pkg;
    localparam int COMPONENT_BITS = 16;
    localparam int MAX_OBJECTS = 8;
    localparam int MASS_BITS = 19;
    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_NEGATIVE = 2'd1;
    localparam logic [1:0] STATUS_TOO_MANY = 2'd2;

    typedef struct packed {
        logic last_object;
        logic signed [COMPONENT_BITS-1:0] comp_y;
        logic signed [COMPONENT_BITS-1:0] comp_x;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [MASS_BITS-1:0] mass;
    } out_item_t;
endpackage
`default_nettype wire

// ----- rtl/tma_isqrt.sv -----
// ----------------------------------------------------------------------------
// tma_isqrt
// pipelined floor square root, one result bit per stage
// ----------------------------------------------------------------------------
`default_nettype none
module tma_isqrt #(
    parameter int IN_BITS = 34,
    parameter int TAG_BITS = 1
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_valid,
    input  wire logic [IN_BITS-1:0] radicand,
    input  wire logic [TAG_BITS-1:0] in_tag,
    output logic out_valid,
    output logic [(IN_BITS+1)/2-1:0] root,
    output logic [TAG_BITS-1:0] out_tag
);
    localparam int RB = (IN_BITS + 1) / 2;
    localparam int VB = 2 * RB;

    logic vld_reg [1:RB];
    logic [VB-1:0] rem_reg [1:RB];
    logic [VB-1:0] val_reg [1:RB];
    logic [RB-1:0] res_reg [1:RB];
    logic [TAG_BITS-1:0] tag_reg [1:RB];

    genvar g;
    generate
        for (g = 0; g < RB; g++)
        begin : g_stage
            logic v_in;
            logic [VB-1:0] rem_in;
            logic [VB-1:0] val_in;
            logic [RB-1:0] res_in;
            logic [TAG_BITS-1:0] tag_cur;
            logic [VB-1:0] rem_next;
            logic [VB-1:0] trial;
            if (g == 0)
            begin : g_head
                assign v_in = in_valid;
                assign rem_in = '0;
                assign val_in = VB'(radicand);
                assign res_in = '0;
                assign tag_cur = in_tag;
            end
            else
            begin : g_body
                assign v_in = vld_reg[g];
                assign rem_in = rem_reg[g];
                assign val_in = val_reg[g];
                assign res_in = res_reg[g];
                assign tag_cur = tag_reg[g];
            end
            assign rem_next = {rem_in[VB-3:0], val_in[VB-1:VB-2]};
            assign trial = (VB'(res_in) << 2) | VB'(1);
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[g+1] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[g+1] <= v_in;
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    val_reg[g+1] <= val_in << 2;
                    tag_reg[g+1] <= tag_cur;
                    if (rem_next >= trial)
                    begin
                        rem_reg[g+1] <= rem_next - trial;
                        res_reg[g+1] <= {res_in[RB-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[g+1] <= rem_next;
                        res_reg[g+1] <= {res_in[RB-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[RB];
    assign root = res_reg[RB];
    assign out_tag = tag_reg[RB];
endmodule
`default_nettype wire

// ----- rtl/tma_front.sv -----
// ----------------------------------------------------------------------------
// tma_front
// takes items, forms magnitudes through a root pipeline, accumulates sums
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module tma_front #(
    parameter int COMPONENT_BITS = tma_pkg::COMPONENT_BITS,
    parameter int MAX_OBJECTS = tma_pkg::MAX_OBJECTS,
    parameter int E_BITS = COMPONENT_BITS + 5,
    parameter int P_BITS = COMPONENT_BITS + 4
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_ready,
    input  wire logic signed [COMPONENT_BITS-1:0] comp_x,
    input  wire logic signed [COMPONENT_BITS-1:0] comp_y,
    input  wire logic last_object,
    output logic set_valid,
    input  wire logic set_ready,
    output logic [E_BITS-1:0] set_e,
    output logic signed [P_BITS-1:0] set_px,
    output logic signed [P_BITS-1:0] set_py,
    output logic set_over
);
    localparam int SQ_BITS = 2 * COMPONENT_BITS + 5;
    localparam int RB = (SQ_BITS + 1) / 2;
    localparam int CNT_BITS = $clog2(MAX_OBJECTS + 1);
    localparam int TAG_BITS = 2 + 2 * COMPONENT_BITS;

    // tag: skip, last, x, y
    logic en;
    logic [COMPONENT_BITS-1:0] ax, ay;
    logic [SQ_BITS-1:0] sq;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic skip;
    logic [TAG_BITS-1:0] tag_in, tag_out;
    logic p_valid;
    logic [RB-1:0] p_root;
    logic [E_BITS-1:0] e_reg, e_next;
    logic signed [P_BITS-1:0] px_reg, py_reg, px_next, py_next;
    logic over_reg, over_next;
    logic out_valid_reg;
    logic [E_BITS-1:0] oe_reg;
    logic signed [P_BITS-1:0] opx_reg, opy_reg;
    logic oover_reg;
    logic acc;

    assign en = !(out_valid_reg && !set_ready);
    assign in_ready = en;
    assign acc = in_valid && in_ready;

    assign ax = comp_x[COMPONENT_BITS-1] ? COMPONENT_BITS'(-comp_x) : comp_x;
    assign ay = comp_y[COMPONENT_BITS-1] ? COMPONENT_BITS'(-comp_y) : comp_y;
    assign sq = (SQ_BITS'(ax) * SQ_BITS'(ax) + SQ_BITS'(ay) * SQ_BITS'(ay)) << 4;
    assign skip = (cnt_reg >= CNT_BITS'(MAX_OBJECTS));
    assign tag_in = {skip, last_object, comp_x, comp_y};

    always_comb
    begin
        cnt_next = cnt_reg;
        if (acc)
        begin
            if (last_object)
                cnt_next = '0;
            else if (!skip)
                cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    tma_isqrt #(.IN_BITS(SQ_BITS), .TAG_BITS(TAG_BITS)) u_root (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(acc), .radicand(sq),
        .in_tag(tag_in), .out_valid(p_valid), .root(p_root), .out_tag(tag_out)
    );

    logic t_skip, t_last;
    logic signed [COMPONENT_BITS-1:0] t_x, t_y;
    assign {t_skip, t_last, t_x, t_y} = tag_out;

    always_comb
    begin
        e_next = e_reg;
        px_next = px_reg;
        py_next = py_reg;
        over_next = over_reg;
        if (t_skip)
            over_next = 1'b1;
        else
        begin
            e_next = e_reg + E_BITS'(p_root);
            px_next = px_reg + P_BITS'(t_x);
            py_next = py_reg + P_BITS'(t_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_reg <= '0;
            px_reg <= '0;
            py_reg <= '0;
            over_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= p_valid && t_last;
            if (p_valid)
            begin
                if (t_last)
                begin
                    e_reg <= '0;
                    px_reg <= '0;
                    py_reg <= '0;
                    over_reg <= 1'b0;
                end
                else
                begin
                    e_reg <= e_next;
                    px_reg <= px_next;
                    py_reg <= py_next;
                    over_reg <= over_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && p_valid && t_last)
        begin
            oe_reg <= e_next;
            opx_reg <= px_next;
            opy_reg <= py_next;
            oover_reg <= over_next;
        end
    end

    assign set_valid = out_valid_reg;
    assign set_e = oe_reg;
    assign set_px = opx_reg;
    assign set_py = opy_reg;
    assign set_over = oover_reg;

    `ASSERT_IMPLIES(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_BITS'(MAX_OBJECTS))
    `ASSERT_NEXT(a_hold, clk, rst_n, set_valid && !set_ready, set_valid && $stable(set_e))
    `ASSERT_IMPLIES(a_stall, clk, rst_n, set_valid && !set_ready, !in_ready)
endmodule
`default_nettype wire

// ----- rtl/tma_back.sv -----
// ----------------------------------------------------------------------------
// tma_back
// forms the mass of a finished set: squares, difference, root, status
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module tma_back #(
    parameter int E_BITS = 21,
    parameter int P_BITS = 20
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic set_valid,
    output logic set_ready,
    input  wire logic [E_BITS-1:0] set_e,
    input  wire logic signed [P_BITS-1:0] set_px,
    input  wire logic signed [P_BITS-1:0] set_py,
    input  wire logic set_over,
    output logic res_valid,
    input  wire logic res_ready,
    output tma_pkg::out_item_t res
);
    localparam int W = (2 * E_BITS > 2 * P_BITS + 5 ? 2 * E_BITS : 2 * P_BITS + 5) + 1;
    localparam int RB = (W + 1) / 2;
    localparam int ST_IDLE = 0;
    localparam int ST_SQ = 1;
    localparam int ST_ROOT = 2;
    localparam int ST_OUT = 3;
    localparam logic [1:0] S_IDLE = 2'(ST_IDLE);
    localparam logic [1:0] S_SQ = 2'(ST_SQ);
    localparam logic [1:0] S_ROOT = 2'(ST_ROOT);
    localparam logic [1:0] S_OUT = 2'(ST_OUT);
    localparam int CB = $clog2(RB + 1);

    logic [1:0] state_reg;
    logic [P_BITS-1:0] ax_in, ay_in;
    logic over_reg;
    logic [W-1:0] e2_reg, x2_reg, y2_reg;
    logic [W-1:0] val_reg, rem_reg;
    logic [RB-1:0] root_reg;
    logic [CB-1:0] cnt_reg;
    logic [W-1:0] rem_next, trial, p2;
    tma_pkg::out_item_t res_reg;

    assign set_ready = (state_reg == S_IDLE);
    assign ax_in = set_px[P_BITS-1] ? P_BITS'(-set_px) : set_px;
    assign ay_in = set_py[P_BITS-1] ? P_BITS'(-set_py) : set_py;
    assign p2 = (x2_reg + y2_reg) << 4;
    assign rem_next = {rem_reg[W-3:0], val_reg[W-1:W-2]};
    assign trial = (W'(root_reg) << 2) | W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (set_valid)
                        state_reg <= S_SQ;
                S_SQ:
                    if (over_reg || e2_reg < p2)
                        state_reg <= S_OUT;
                    else
                    begin
                        state_reg <= S_ROOT;
                        cnt_reg <= CB'(RB);
                    end
                S_ROOT:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CB'(1))
                        state_reg <= S_OUT;
                end
                S_OUT:
                    if (res_ready)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (set_valid)
                begin
                    over_reg <= set_over;
                    e2_reg <= W'(set_e) * W'(set_e);
                    x2_reg <= W'(ax_in) * W'(ax_in);
                    y2_reg <= W'(ay_in) * W'(ay_in);
                end
            S_SQ:
            begin
                val_reg <= e2_reg - p2;
                rem_reg <= '0;
                root_reg <= '0;
                if (over_reg)
                    res_reg <= '{status: tma_pkg::STATUS_TOO_MANY, mass: '0};
                else if (e2_reg < p2)
                    res_reg <= '{status: tma_pkg::STATUS_NEGATIVE, mass: '0};
            end
            S_ROOT:
            begin
                val_reg <= val_reg << 2;
                if (rem_next >= trial)
                begin
                    rem_reg <= rem_next - trial;
                    root_reg <= {root_reg[RB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_next;
                    root_reg <= {root_reg[RB-2:0], 1'b0};
                end
                if (cnt_reg == CB'(1))
                    res_reg <= '{status: tma_pkg::STATUS_OK,
                        mass: tma_pkg::MASS_BITS'((rem_next >= trial ?
                            {root_reg[RB-2:0], 1'b1} : {root_reg[RB-2:0], 1'b0}) >> 2)};
            end
            S_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign res_valid = (state_reg == S_OUT);
    assign res = res_reg;

    `ASSERT_IMPLIES(a_ready_idle, clk, rst_n, set_ready, !res_valid)
    `ASSERT_NEXT(a_out_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res))
    `ASSERT_IMPLIES(a_status, clk, rst_n, res_valid, res.status != 2'd3)
endmodule
`default_nettype wire

// ----- rtl/transverse_mass_accumulator.sv -----
// ----------------------------------------------------------------------------
// transverse_mass_accumulator
// throughput: one item per cycle into the root pipeline while the front part is not
// stalled by a set that the back part has not taken; the back part takes a new set
// only after the result of the last one has left, since its single root is serial
// reset: rst_n clears all sums, counts and valid flags asynchronously
// ----------------------------------------------------------------------------
`default_nettype none
module transverse_mass_accumulator #(
    parameter int MAX_OBJECTS = tma_pkg::MAX_OBJECTS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_ready,
    input  wire tma_pkg::in_item_t in_item,
    output logic out_valid,
    input  wire logic out_ready,
    output tma_pkg::out_item_t out_item
);
    localparam int COMPONENT_BITS = tma_pkg::COMPONENT_BITS;
    localparam int E_BITS = COMPONENT_BITS + 5;
    localparam int P_BITS = COMPONENT_BITS + 4;

    logic set_valid, set_ready, set_over;
    logic [E_BITS-1:0] set_e;
    logic signed [P_BITS-1:0] set_px, set_py;

    tma_front #(.COMPONENT_BITS(COMPONENT_BITS), .MAX_OBJECTS(MAX_OBJECTS),
        .E_BITS(E_BITS), .P_BITS(P_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .comp_x(in_item.comp_x), .comp_y(in_item.comp_y),
        .last_object(in_item.last_object),
        .set_valid(set_valid), .set_ready(set_ready), .set_e(set_e),
        .set_px(set_px), .set_py(set_py), .set_over(set_over)
    );

    tma_back #(.E_BITS(E_BITS), .P_BITS(P_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .set_valid(set_valid), .set_ready(set_ready),
        .set_e(set_e), .set_px(set_px), .set_py(set_py), .set_over(set_over),
        .res_valid(out_valid), .res_ready(out_ready), .res(out_item)
    );
endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// transverse mass accumulator check: sets of momentum vectors are sent with
// random gaps, a local model predicts the mass and status of each set and a
// monitor compares every result item against the oldest prediction
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    tma_pkg::in_item_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    tma_pkg::out_item_t out_item;

    logic [63:0] energy_acc;
    logic signed [63:0] px_acc;
    logic signed [63:0] py_acc;
    int obj_count;
    bit too_many;
    tma_pkg::out_item_t mass_queue[$];
    int errors = 0;
    bit no_idle = 1'b0;

    transverse_mass_accumulator i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
        .out_item(out_item)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] absval(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    task automatic predict_mass(tma_pkg::in_item_t it);
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] e2;
        logic [63:0] p2;
        tma_pkg::out_item_t r;
        if (obj_count >= tma_pkg::MAX_OBJECTS)
            too_many = 1'b1;
        else
        begin
            ax = absval(64'(it.comp_x));
            ay = absval(64'(it.comp_y));
            energy_acc += isqrt(16 * (ax * ax + ay * ay));
            px_acc += 64'(it.comp_x);
            py_acc += 64'(it.comp_y);
            obj_count++;
        end
        if (it.last_object)
        begin
            r = '0;
            r.status = tma_pkg::STATUS_OK;
            if (too_many)
                r.status = tma_pkg::STATUS_TOO_MANY;
            else
            begin
                ax = absval(px_acc);
                ay = absval(py_acc);
                e2 = energy_acc * energy_acc;
                p2 = 16 * (ax * ax + ay * ay);
                if (e2 < p2)
                    r.status = tma_pkg::STATUS_NEGATIVE;
                else
                    r.mass = tma_pkg::MASS_BITS'(isqrt(e2 - p2) >> 2);
            end
            mass_queue.push_back(r);
            energy_acc = 0;
            px_acc = 0;
            py_acc = 0;
            obj_count = 0;
            too_many = 1'b0;
        end
    endtask

    task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y, bit last);
        tma_pkg::in_item_t it;
        while (!no_idle && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        it.comp_x = x;
        it.comp_y = y;
        it.last_object = last;
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_mass(it);
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(3))
            0: return $urandom_range(15) - 8;
            1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_extremes();
        send_vector(16'sh7fff, 16'sh7fff, 1'b0);
        send_vector(16'sh7fff, 16'sh7fff, 1'b1);
        send_vector(16'sh8000, 16'sh8000, 1'b0);
        send_vector(16'sh7fff, 16'sh8000, 1'b1);
        send_vector(16'sh8000, 16'sh0000, 1'b0);
        send_vector(16'sh7fff, 16'sh0000, 1'b1);
        send_vector(16'sh0000, 16'sh0000, 1'b1);
        send_vector(16'sh0001, 16'sh0001, 1'b1);
    endtask

    task automatic test_negative_square();
        // collinear vectors lose fractions in magnitudes
        send_vector(16'sd1, 16'sd1, 1'b0);
        send_vector(16'sd1, 16'sd1, 1'b0);
        send_vector(16'sd1, 16'sd1, 1'b1);
        send_vector(16'sd3, 16'sd5, 1'b0);
        send_vector(16'sd3, 16'sd5, 1'b1);
    endtask

    task automatic test_too_many();
        for (int i = 0; i < 10; i++)
            send_vector(rand_comp(), rand_comp(), i == 9);
        for (int i = 0; i < 8; i++)
            send_vector(rand_comp(), rand_comp(), i == 7);
    endtask

    task automatic test_random_sets();
        int sent;
        int len;
        sent = 0;
        while (sent < 1250)
        begin
            no_idle = (sent > 500 && sent < 700);
            len = ($urandom_range(9) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 1);
            for (int i = 0; i < len; i++)
                send_vector(rand_comp(), rand_comp(), i == len - 1);
            sent += len;
        end
        no_idle = 1'b0;
    endtask

    always @(posedge clk)
    begin
        out_ready <= no_idle || ($urandom_range(99) >= 19);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (mass_queue.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", out_item);
            end
            else if (out_item !== mass_queue[0])
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch expected %p actual %p", mass_queue[0], out_item);
                void'(mass_queue.pop_front());
            end
            else
                void'(mass_queue.pop_front());
        end
    end

    initial
    begin
        energy_acc = 0;
        px_acc = 0;
        py_acc = 0;
        obj_count = 0;
        too_many = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_negative_square();
        test_too_many();
        test_random_sets();
        in_valid <= 1'b0;
        while (mass_queue.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0 && mass_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tma_pkg.sv
rtl/tma_isqrt.sv
rtl/tma_front.sv
rtl/tma_back.sv
rtl/transverse_mass_accumulator.sv
tb/sv/testbench.sv
